// ===== src/dsv_pkg.sv =====
`default_nettype none

package dsv_pkg;

    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [2:0] PH_DAY   = 3'd0;
    localparam logic [2:0] PH_MONTH = 3'd1;
    localparam logic [2:0] PH_YEAR  = 3'd2;
    localparam logic [2:0] PH_TAIL  = 3'd3;
    localparam logic [2:0] PH_FAIL  = 3'd4;

    localparam logic [5:0]  DAY_CAP   = 6'd63;
    localparam logic [3:0]  MONTH_CAP = 4'd15;
    localparam logic [13:0] YEAR_CAP  = 14'd16383;
    localparam logic [2:0]  COUNT_CAP = 3'd7;

    localparam logic [5:0] DAY_MAX   = 6'd31;
    localparam logic [3:0] MONTH_MAX = 4'd12;
    localparam logic [5:0] LIM_SHORT = 6'd30;
    localparam logic [5:0] LIM_LEAP  = 6'd29;
    localparam logic [5:0] LIM_FEB   = 6'd28;

    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;

    localparam logic [2:0] YEAR_DIGITS_SHORT = 3'd2;
    localparam logic [2:0] YEAR_DIGITS_LONG  = 3'd4;

    // parser state; year_bcd holds the last four year digits
    typedef struct packed {
        logic [2:0]  phase;
        logic [5:0]  day_acc;
        logic [3:0]  month_acc;
        logic [13:0] year_acc;
        logic [2:0]  digit_count;
        logic [15:0] year_bcd;
    } parse_t;

    typedef struct packed {
        logic        valid_res;
        logic [5:0]  day_value;
        logic [3:0]  month_value;
        logic [13:0] year_value;
    } result_t;

endpackage

`default_nettype wire

// ===== src/dsv_parser.sv =====
`default_nettype none

module dsv_parser (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           step,
    input  wire logic [7:0]     char_code,
    input  wire logic           last,
    output dsv_pkg::parse_t     fin_state
);
    import dsv_pkg::*;

    parse_t state_reg;
    parse_t state_next;

    logic        dig;
    logic [3:0]  d;
    logic [9:0]  day_push;
    logic [7:0]  month_push;
    logic [17:0] year_push;
    logic [2:0]  count_inc;

    always_comb begin
        dig        = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
        d          = dig ? 4'(char_code - CHAR_ZERO) : 4'd0;
        day_push   = ({4'd0, state_reg.day_acc} << 3) + ({4'd0, state_reg.day_acc} << 1)
                     + {6'd0, d};
        month_push = ({4'd0, state_reg.month_acc} << 3) + ({4'd0, state_reg.month_acc} << 1)
                     + {4'd0, d};
        year_push  = ({4'd0, state_reg.year_acc} << 3) + ({4'd0, state_reg.year_acc} << 1)
                     + {14'd0, d};
        count_inc  = (state_reg.digit_count < COUNT_CAP) ? state_reg.digit_count + 3'd1
                                                         : state_reg.digit_count;
        state_next = state_reg;
        case (state_reg.phase)
            PH_DAY, PH_MONTH: begin
                if (dig) begin
                    if (state_reg.phase == PH_DAY) begin
                        state_next.day_acc = (day_push > {4'd0, DAY_CAP}) ? DAY_CAP
                                                                           : day_push[5:0];
                    end else begin
                        state_next.month_acc = (month_push > {4'd0, MONTH_CAP}) ? MONTH_CAP
                                                                                 : month_push[3:0];
                    end
                    state_next.digit_count = count_inc;
                end else if (char_code == CHAR_SLASH && state_reg.digit_count != 3'd0) begin
                    state_next.phase       = state_reg.phase + 3'd1;
                    state_next.digit_count = 3'd0;
                end else begin
                    state_next.phase = PH_FAIL;
                end
            end
            PH_YEAR: begin
                if (dig) begin
                    state_next.year_acc    = (year_push > {4'd0, YEAR_CAP}) ? YEAR_CAP
                                                                             : year_push[13:0];
                    state_next.year_bcd    = {state_reg.year_bcd[11:0], d};
                    state_next.digit_count = count_inc;
                end else begin
                    state_next.phase = PH_TAIL;
                end
            end
            PH_TAIL: begin
                state_next = state_reg;
            end
            default: begin
                state_next.phase = PH_FAIL;
            end
        endcase
    end

    assign fin_state = state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (step) begin
            if (last) begin
                state_reg <= '0;
            end else begin
                state_reg <= state_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/dsv_check.sv =====
`default_nettype none

module dsv_check (
    input  wire dsv_pkg::parse_t  fin_state,
    output dsv_pkg::result_t      result
);
    import dsv_pkg::*;

    logic [3:0] y0, y1, y2, y3;
    logic       lo_zero;
    logic       lo_div4;
    logic       hi_div4;
    logic       leap;
    logic [5:0] lim;
    logic       ok;

    always_comb begin
        y0      = fin_state.year_bcd[3:0];
        y1      = fin_state.year_bcd[7:4];
        y2      = fin_state.year_bcd[11:8];
        y3      = fin_state.year_bcd[15:12];
        // year mod 4 follows from the last two digits, mod 400 adds the upper two
        lo_zero = (y0 == 4'd0) && (y1 == 4'd0);
        lo_div4 = (2'({y1[0], 1'b0}) + y0[1:0]) == 2'd0;
        hi_div4 = (2'({y3[0], 1'b0}) + y2[1:0]) == 2'd0;
        leap    = (lo_div4 && !lo_zero) || (lo_zero && hi_div4);

        case (fin_state.month_acc)
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: lim = LIM_SHORT;
            MONTH_FEB: lim = leap ? LIM_LEAP : LIM_FEB;
            default:   lim = DAY_MAX;
        endcase

        ok = (fin_state.phase == PH_YEAR || fin_state.phase == PH_TAIL)
             && (fin_state.digit_count == YEAR_DIGITS_SHORT
                 || fin_state.digit_count == YEAR_DIGITS_LONG)
             && (fin_state.day_acc != 6'd0) && (fin_state.day_acc <= DAY_MAX)
             && (fin_state.month_acc != 4'd0) && (fin_state.month_acc <= MONTH_MAX)
             && (fin_state.day_acc <= lim);

        result.valid_res   = ok;
        result.day_value   = ok ? fin_state.day_acc   : 6'd0;
        result.month_value = ok ? fin_state.month_acc : 4'd0;
        result.year_value  = ok ? fin_state.year_acc  : 14'd0;
    end

endmodule

`default_nettype wire

// ===== src/date_string_validator.sv =====
// Date text validator. Takes a day/month/year text one ASCII byte per word
// on the s_ channel, s_last marking the final byte, and gives one result word
// on the m_ channel for each text: m_valid_res and the parsed day, month and
// year (all zero when the text is not a valid date). A byte is registered on
// input, parsed and checked combinationally into the result register, so a
// byte is taken every cycle and a text's result is held there after its last
// byte; the rate drops only while a result waits in the output register and
// another last byte is ready behind it. Day and month need one or more digits
// and a slash, the year exactly two or four digits; anything after the year
// is ignored. Leap years follow the 4/100/400 rule on the year as written.
`default_nettype none

module date_string_validator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_char_code,
    input  wire logic        s_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_valid_res,
    output logic [5:0]       m_day_value,
    output logic [3:0]       m_month_value,
    output logic [13:0]      m_year_value
);
    import dsv_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    logic       advance;
    parse_t     fin_state;
    result_t    result;

    assign advance = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_char_reg <= s_char_code;
            in_last_reg <= s_last;
        end
    end

    dsv_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .char_code (in_char_reg),
        .last      (in_last_reg),
        .fin_state (fin_state)
    );

    dsv_check u_check (
        .fin_state (fin_state),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_reg <= result;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_valid_res   = out_reg.valid_res;
    assign m_day_value   = out_reg.day_value;
    assign m_month_value = out_reg.month_value;
    assign m_year_value  = out_reg.year_value;

endmodule

`default_nettype wire

// ===== src/date_string_validator_checker.sv =====
`default_nettype none

module date_string_validator_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        s_last,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_valid_res,
    input wire logic [5:0]  m_day_value,
    input wire logic [3:0]  m_month_value,
    input wire logic [13:0] m_year_value
);

    // texts whose last byte went in and whose result word has not gone out
    logic [1:0] open_reg;
    logic [1:0] open_next;

    always_comb begin
        open_next = open_reg + 2'(s_valid && s_ready && s_last) - 2'(m_valid && m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= 2'd0;
        end else begin
            open_reg <= open_next;
        end
    end

    // no result word right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid after reset");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_valid_res) && $stable(m_day_value)
            && $stable(m_month_value) && $stable(m_year_value))
        else $error("stalled result word changed");

    // invalid date carries zero fields
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_valid_res |-> m_day_value == 6'd0 && m_month_value == 4'd0
            && m_year_value == 14'd0)
        else $error("invalid result with nonzero fields");

    // valid date is in range
    a_valid_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_valid_res |-> m_day_value != 6'd0 && m_day_value <= 6'd31
            && m_month_value != 4'd0 && m_month_value <= 4'd12
            && m_year_value <= 14'd9999)
        else $error("valid result out of range");

    // no result word can appear without a last byte having gone in
    a_result_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> open_reg != 2'd0)
        else $error("result word without cause");

endmodule

bind date_string_validator date_string_validator_checker u_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_last        (s_last),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_valid_res   (m_valid_res),
    .m_day_value   (m_day_value),
    .m_month_value (m_month_value),
    .m_year_value  (m_year_value)
);

`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dsv_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_PRINTS  = 20;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_char_code = 8'h00;
    logic        s_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_valid_res;
    logic [5:0]  m_day_value;
    logic [3:0]  m_month_value;
    logic [13:0] m_year_value;

    date_string_validator u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_valid_res   (m_valid_res),
        .m_day_value   (m_day_value),
        .m_month_value (m_month_value),
        .m_year_value  (m_year_value)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // parser copy
    logic [2:0]  ps_phase = PH_DAY;
    logic [5:0]  ps_day = '0;
    logic [3:0]  ps_month = '0;
    logic [13:0] ps_year = '0;
    logic [2:0]  ps_digits = '0;

    result_t     pending_dates[$];
    logic [7:0]  text_buf[$];

    bit idle_on = 1'b1;
    bit hold_req = 1'b0;
    int errors = 0;
    int chars_accepted = 0;
    int dates_checked = 0;
    int dates_valid = 0;

    function automatic int sat_push(input int acc, input int digit, input int cap);
        int v;
        v = acc * 10 + digit;
        return (v > cap) ? cap : v;
    endfunction

    function automatic void parse_clear();
        ps_phase  = PH_DAY;
        ps_day    = '0;
        ps_month  = '0;
        ps_year   = '0;
        ps_digits = '0;
    endfunction

    function automatic bit parse_byte(input logic [7:0] c, input logic fin,
                                      output result_t res);
        bit is_dig;
        bit ok;
        bit leap;
        int digit;
        int lim;
        is_dig = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        digit  = is_dig ? int'(c - CHAR_ZERO) : 0;
        if (ps_phase > PH_FAIL) begin
            ps_phase = PH_FAIL;
        end
        if (ps_phase == PH_DAY || ps_phase == PH_MONTH) begin
            if (is_dig) begin
                if (ps_phase == PH_DAY) begin
                    ps_day = 6'(sat_push(ps_day, digit, DAY_CAP));
                end else begin
                    ps_month = 4'(sat_push(ps_month, digit, MONTH_CAP));
                end
                if (ps_digits != COUNT_CAP) ps_digits = ps_digits + 3'd1;
            end else if (c == CHAR_SLASH && ps_digits != 0) begin
                ps_phase  = ps_phase + 3'd1;
                ps_digits = '0;
            end else begin
                ps_phase = PH_FAIL;
            end
        end else if (ps_phase == PH_YEAR) begin
            if (is_dig) begin
                ps_year = 14'(sat_push(ps_year, digit, YEAR_CAP));
                if (ps_digits != COUNT_CAP) ps_digits = ps_digits + 3'd1;
            end else begin
                ps_phase = PH_TAIL;
            end
        end
        res = '0;
        if (!fin) return 1'b0;

        ok = (ps_phase == PH_YEAR || ps_phase == PH_TAIL)
            && (ps_digits == YEAR_DIGITS_SHORT || ps_digits == YEAR_DIGITS_LONG)
            && ps_day >= 1 && ps_day <= DAY_MAX
            && ps_month >= 1 && ps_month <= MONTH_MAX;
        leap = ((ps_year % 4 == 0) && (ps_year % 100 != 0)) || (ps_year % 400 == 0);
        if (ps_month == MONTH_APR || ps_month == MONTH_JUN ||
            ps_month == MONTH_SEP || ps_month == MONTH_NOV) begin
            lim = LIM_SHORT;
        end else if (ps_month == MONTH_FEB) begin
            lim = leap ? LIM_LEAP : LIM_FEB;
        end else begin
            lim = DAY_MAX;
        end
        ok = ok && (ps_day <= lim);
        res.valid_res   = ok;
        res.day_value   = ok ? ps_day : '0;
        res.month_value = ok ? ps_month : '0;
        res.year_value  = ok ? ps_year : '0;
        parse_clear();
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTS) $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    // input predictor and result checker
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            parse_clear();
        end else begin
            if (s_valid && s_ready) begin
                chars_accepted++;
                if (parse_byte(s_char_code, s_last, want)) pending_dates.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (pending_dates.size() == 0) begin
                    report_mismatch("result word with no date text pending");
                end else begin
                    want = pending_dates.pop_front();
                    dates_checked++;
                    if (want.valid_res) dates_valid++;
                    if (m_valid_res !== want.valid_res)
                        report_mismatch($sformatf("valid_res got %0b want %0b",
                            m_valid_res, want.valid_res));
                    if (m_day_value !== want.day_value)
                        report_mismatch($sformatf("day_value got %0d want %0d",
                            m_day_value, want.day_value));
                    if (m_month_value !== want.month_value)
                        report_mismatch($sformatf("month_value got %0d want %0d",
                            m_month_value, want.month_value));
                    if (m_year_value !== want.year_value)
                        report_mismatch($sformatf("year_value got %0d want %0d",
                            m_year_value, want.year_value));
                end
            end
        end
    end

    // receiver with random stalls and one long hold-off
    initial begin
        int n;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++) @(posedge aclk);
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
        $display("testbench failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] c, input logic fin);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_char_code <= c;
        s_last      <= fin;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_text();
        int i;
        for (i = 0; i < text_buf.size(); i++) send_byte(text_buf[i], i == text_buf.size() - 1);
    endtask

    task automatic send_str(input string s);
        int i;
        text_buf.delete();
        for (i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
        send_text();
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic put_num(input int value, input int ndig);
        int i;
        for (i = ndig - 1; i >= 0; i--)
            text_buf.push_back(CHAR_ZERO + 8'((value / (10 ** i)) % 10));
    endtask

    task automatic build_date();
        int day;
        int month;
        int year;
        int ndig;
        text_buf.delete();
        case ($urandom_range(0, 7))
            0, 1: month = MONTH_FEB;
            2: month = $urandom_range(0, 99);
            default: month = $urandom_range(1, 12);
        endcase
        case ($urandom_range(0, 7))
            0: day = $urandom_range(0, 99);
            1, 2: day = $urandom_range(28, 31);
            default: day = $urandom_range(1, 31);
        endcase
        ndig = (day < 10) ? $urandom_range(1, 2) : 2;
        if ($urandom_range(0, 15) == 0) ndig = 3;
        put_num(day, ndig);
        text_buf.push_back(CHAR_SLASH);
        ndig = (month < 10) ? $urandom_range(1, 2) : 2;
        if ($urandom_range(0, 15) == 0) ndig = 3;
        put_num(month, ndig);
        text_buf.push_back(CHAR_SLASH);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: ndig = 4;
            4, 5, 6: ndig = 2;
            7: ndig = 1;
            8: ndig = 3;
            default: ndig = $urandom_range(5, 8);
        endcase
        case ($urandom_range(0, 3))
            0: year = 400 * $urandom_range(0, 24);
            1: year = 100 * $urandom_range(0, 99);
            2: year = 4 * $urandom_range(0, 2499);
            default: year = $urandom_range(0, 9999);
        endcase
        if (ndig > 4) year = $urandom_range(0, 99999999);
        put_num(year, ndig);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) text_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic build_any_text();
        int kind;
        int pos;
        kind = $urandom_range(0, 19);
        if (kind < 17) begin
            build_date();
        end else begin
            text_buf.delete();
            repeat ($urandom_range(1, 8)) text_buf.push_back(8'($urandom_range(0, 255)));
        end
        if (kind >= 14 && kind < 17) begin
            pos = $urandom_range(0, text_buf.size() - 1);
            case ($urandom_range(0, 2))
                0: text_buf = text_buf[0:pos];
                1: text_buf[pos] = 8'($urandom_range(0, 255));
                default: text_buf[pos] = CHAR_SLASH;
            endcase
        end
    endtask

    task automatic test_directed();
        text_buf.delete();
        text_buf.push_back(8'hFF);
        send_text();
        send_str("/");
        send_str("1/1/");
        send_str("31/4/21");
        send_str("29/2/00x");
        send_str("1/12/2024");
        wait_drained();
    endtask

    task automatic test_random(input int char_goal);
        while (chars_accepted < char_goal) begin
            if ($urandom_range(0, 7) == 0) idle_on = !idle_on;
            build_any_text();
            send_text();
        end
        idle_on = 1'b1;
        wait_drained();
    endtask

    task automatic test_backpressure();
        int n;
        hold_req = 1'b1;
        for (n = 0; n < 12; n++) begin
            build_date();
            send_text();
        end
        wait_drained();
    endtask

    task automatic test_no_idle(input int char_goal);
        idle_on = 1'b0;
        while (chars_accepted < char_goal) begin
            build_any_text();
            send_text();
        end
        wait_drained();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(720);
        test_backpressure();
        test_no_idle(950);
        repeat (8) @(posedge aclk);
        $display("checked %0d date texts (%0d valid) built from %0d characters",
            dates_checked, dates_valid, chars_accepted);
        $display("covered bad bytes, empty fields, leap rules, tails, saturation and stalls");
        if (errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("%0d mismatches", errors);
            $display("testbench failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
